[rtl/dafmt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dafmt_pkg
// Shared widths, character codes and digit types of the decimal formatter.
// ----------------------------------------------------------------------------
package dafmt_pkg;

  localparam int ValueW   = 16;
  localparam int CharW    = 8;
  localparam int DigitW   = 4;
  localparam int NumLead  = 4;
  localparam int NumChars = NumLead + 1;
  localparam int CntW     = $clog2(NumChars + 1);
  localparam int LeadIdxW = $clog2(NumLead);

  localparam logic [CharW-1:0] AsciiZero      = 8'd48;
  localparam logic [CharW-1:0] CarriageReturn = 8'h0D;

  typedef logic [DigitW-1:0] digit_t;
  typedef digit_t [NumLead-1:0] lead_t;
  typedef logic [CharW-1:0] char_t;

endpackage
`default_nettype wire

[rtl/decimal_ascii_formatter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_ascii_formatter
// 16-bit unsigned value to decimal ASCII text, leading zeros dropped.
// ----------------------------------------------------------------------------
// path: the first character is offered once the value has passed the four
//   digit stage registers and has been loaded into the serializer
// throughput: 2 to 5 characters per value; the output shifter emits one
//   character per cycle while character_stall is low and sets the rate
// four digit stages can hold further values while the shifter drains
// reset: synchronous, clears all stage valid bits and the character count
// ----------------------------------------------------------------------------
module decimal_ascii_formatter (
  input  wire                         clk,
  input  wire                         rst,
  input  wire [dafmt_pkg::ValueW-1:0] value,
  input  wire                         value_valid,
  output logic                        value_stall,
  output logic [dafmt_pkg::CharW-1:0] character,
  output logic                        last_char,
  output logic                        character_valid,
  input  wire                         character_stall
);

  localparam int NumStages = dafmt_pkg::NumLead;
  localparam int Weights [NumStages] = '{10000, 1000, 100, 10};

  logic                         vld   [NumStages+1];
  logic                         stall [NumStages+1];
  logic [dafmt_pkg::ValueW-1:0] rem   [NumStages+1];
  dafmt_pkg::lead_t             lead  [NumStages+1];

  assign vld[0]      = value_valid;
  assign value_stall = stall[0];
  assign rem[0]      = value;
  assign lead[0]     = '0;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    dafmt_stage #(
      .Weight (Weights[s]),
      .Slot   (s)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .src_valid (vld[s]),
      .src_stall (stall[s]),
      .src_rem   (rem[s]),
      .src_lead  (lead[s]),
      .dst_valid (vld[s+1]),
      .dst_stall (stall[s+1]),
      .dst_rem   (rem[s+1]),
      .dst_lead  (lead[s+1])
    );
  end

  dafmt_ser u_ser (
    .clk             (clk),
    .rst             (rst),
    .src_valid       (vld[NumStages]),
    .src_stall       (stall[NumStages]),
    .src_lead        (lead[NumStages]),
    .src_units       (rem[NumStages][dafmt_pkg::DigitW-1:0]),
    .character       (character),
    .last_char       (last_char),
    .character_valid (character_valid),
    .character_stall (character_stall)
  );

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    character_valid |-> ((character >= dafmt_pkg::AsciiZero &&
                          character <= dafmt_pkg::AsciiZero + 8'd9) ||
                         character == dafmt_pkg::CarriageReturn))
    else $error("character out of range");

  a_cr_last: assert property (@(posedge clk) disable iff (rst)
    (character_valid && character == dafmt_pkg::CarriageReturn) |-> last_char)
    else $error("carriage return not flagged last");

  a_units_rem: assert property (@(posedge clk) disable iff (rst)
    vld[NumStages] |-> (rem[NumStages] < dafmt_pkg::ValueW'(10)))
    else $error("units remainder too large");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !character_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

[rtl/dafmt_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dafmt_stage
// One pipeline stage: splits off the decimal digit of one weight and passes
// the remainder on.
// ----------------------------------------------------------------------------
module dafmt_stage #(
  parameter int Weight = 10000,
  parameter int Slot   = 0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          src_valid,
  output logic                         src_stall,
  input  wire [dafmt_pkg::ValueW-1:0]  src_rem,
  input  wire dafmt_pkg::lead_t        src_lead,
  output logic                         dst_valid,
  input  wire                          dst_stall,
  output logic [dafmt_pkg::ValueW-1:0] dst_rem,
  output dafmt_pkg::lead_t             dst_lead
);

  logic                         advance;
  dafmt_pkg::digit_t            digit;
  logic [dafmt_pkg::ValueW:0]   sub;
  logic [dafmt_pkg::ValueW-1:0] rem_next;
  dafmt_pkg::lead_t             lead_next;

  assign advance   = !dst_valid || !dst_stall;
  assign src_stall = !advance;

  // parallel compares against the multiples of the weight
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, src_rem} >= (dafmt_pkg::ValueW+1)'(k * Weight)) begin
        digit = dafmt_pkg::DigitW'(k);
        sub   = (dafmt_pkg::ValueW+1)'(k * Weight);
      end
    end
    rem_next  = src_rem - sub[dafmt_pkg::ValueW-1:0];
    lead_next = src_lead;
    lead_next[dafmt_pkg::LeadIdxW'(Slot)] = digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dst_rem  <= rem_next;
      dst_lead <= lead_next;
    end
  end

endmodule
`default_nettype wire

[rtl/dafmt_ser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dafmt_ser
// Character serializer: drops leading zeros, converts digits to ASCII and
// shifts out one character per transfer.
// ----------------------------------------------------------------------------
module dafmt_ser (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         src_valid,
  output logic                        src_stall,
  input  wire dafmt_pkg::lead_t       src_lead,
  input  wire dafmt_pkg::digit_t      src_units,
  output dafmt_pkg::char_t            character,
  output logic                        last_char,
  output logic                        character_valid,
  input  wire                         character_stall
);

  localparam int IdxW = $clog2(2 * dafmt_pkg::NumChars);

  dafmt_pkg::char_t            chars [dafmt_pkg::NumChars];
  logic [dafmt_pkg::CntW-1:0]  cnt;
  logic                        can_load;
  logic                        load;
  logic                        shift;
  dafmt_pkg::digit_t           digs [dafmt_pkg::NumChars];
  logic [IdxW-1:0]             first;
  logic [IdxW-1:0]             idx;
  dafmt_pkg::char_t            chars_next [dafmt_pkg::NumChars];
  logic [dafmt_pkg::CntW-1:0]  cnt_next;

  assign character_valid = (cnt != '0);
  assign character       = chars[0];
  assign last_char       = (cnt == dafmt_pkg::CntW'(1));

  assign shift     = character_valid && !character_stall;
  assign can_load  = (cnt == '0) || ((cnt == dafmt_pkg::CntW'(1)) && !character_stall);
  assign load      = src_valid && can_load;
  assign src_stall = !can_load;

  always_comb begin
    for (int i = 0; i < dafmt_pkg::NumLead; i++) begin
      digs[i] = src_lead[i];
    end
    digs[dafmt_pkg::NumLead] = src_units;

    first = IdxW'(dafmt_pkg::NumLead);
    for (int i = dafmt_pkg::NumLead - 1; i >= 0; i--) begin
      if (digs[i] != '0) begin
        first = IdxW'(i);
      end
    end

    for (int j = 0; j < dafmt_pkg::NumChars; j++) begin
      idx = first + IdxW'(j);
      chars_next[j] = '0;
      if (idx < IdxW'(dafmt_pkg::NumChars)) begin
        chars_next[j] = dafmt_pkg::AsciiZero
                      + dafmt_pkg::CharW'(digs[idx[$clog2(dafmt_pkg::NumChars)-1:0]]);
      end
    end
    idx = '0;

    if (first == IdxW'(dafmt_pkg::NumLead)) begin
      // single digit gets a carriage return behind it
      chars_next[1] = dafmt_pkg::CarriageReturn;
      cnt_next      = dafmt_pkg::CntW'(2);
    end else begin
      cnt_next = dafmt_pkg::CntW'(IdxW'(dafmt_pkg::NumChars) - first);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= cnt_next;
    end else if (shift) begin
      cnt <= cnt - dafmt_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= chars_next;
    end else if (shift) begin
      for (int j = 0; j < dafmt_pkg::NumChars - 1; j++) begin
        chars[j] <= chars[j+1];
      end
    end
  end

endmodule
`default_nettype wire
